// ----- rtl/ptbp_pkg.sv -----
// Shared types and constants of the per-branch two-bit predictor.
package ptbp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned QPTR_W            = 1;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned ENTRIES_W = 9;
  localparam int unsigned ENTRY_W   = ADDR_W + CNT_W;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MIN       = 2'd0;
  localparam logic [CNT_W-1:0] CNT_MAX       = 2'd3;
  localparam logic [CNT_W-1:0] CNT_TAKEN_MIN = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PREDICT = 2'd1,
    KIND_UPDATE  = 2'd2,
    KIND_NOP     = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   addr;
    logic                taken;
  } queue_entry_t;

  // Valid-qualified entry travelling between front, queue and back
  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_xfer_t;

endpackage

// ----- rtl/ptbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ptbp_front.sv -----
// Command intake: accepts a transaction and classifies its operation.
module ptbp_front #(
  parameter int unsigned TABLE_ENTRIES = ptbp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          start,
  output logic                          busy,
  input  logic [ptbp_pkg::OP_W-1:0]     operation_i,
  input  logic [ptbp_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptbp_pkg::ADDR_W-1:0]   branch_address_i,
  input  logic                          taken_i,
  input  logic                          q_full_i,
  output ptbp_pkg::queue_xfer_t         push_o
);

  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SLW = (CW > ptbp_pkg::SLOT_W) ? CW : ptbp_pkg::SLOT_W;

  ptbp_pkg::op_kind_e kind;

  always_comb begin
    unique case (operation_i)
      ptbp_pkg::OP_LOAD:    kind = ptbp_pkg::KIND_LOAD;
      ptbp_pkg::OP_PREDICT: kind = ptbp_pkg::KIND_PREDICT;
      ptbp_pkg::OP_UPDATE:  kind = ptbp_pkg::KIND_UPDATE;
      default:              kind = ptbp_pkg::KIND_NOP;
    endcase
  end

  assign busy = q_full_i;

  always_comb begin
    push_o.valid         = start && !q_full_i;
    push_o.entry.kind    = kind;
    // loads beyond the table are dropped later
    push_o.entry.slot_ok = SLW'(slot_i) < SLW'(TABLE_ENTRIES);
    push_o.entry.slot    = slot_i;
    push_o.entry.addr    = branch_address_i;
    push_o.entry.taken   = taken_i;
  end

endmodule

// ----- rtl/ptbp_fifo.sv -----
// Short command queue between intake and execution.
module ptbp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptbp_pkg::queue_xfer_t push_i,
  output logic                  full_o,
  output ptbp_pkg::queue_xfer_t head_o,
  input  logic                  pop_i
);

  localparam int unsigned CNTW = $clog2(ptbp_pkg::QUEUE_DEPTH + 1);

  ptbp_pkg::queue_entry_t           store_q [ptbp_pkg::QUEUE_DEPTH];
  logic [ptbp_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ptbp_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]                  count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = count_q == CNTW'(ptbp_pkg::QUEUE_DEPTH);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.entry = store_q[rd_ptr_q];

endmodule

// ----- rtl/ptbp_back.sv -----
// Execution sequencer: loads slots, scans the table and updates counters.
module ptbp_back #(
  parameter int unsigned TABLE_ENTRIES = ptbp_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptbp_pkg::queue_xfer_t            head_i,
  output logic                             pop_o,
  input  logic [ptbp_pkg::ENTRIES_W-1:0]   entries_in_use_i,
  output logic                             ram_we_o,
  output logic [AW-1:0]                    ram_waddr_o,
  output logic [ptbp_pkg::ENTRY_W-1:0]     ram_wdata_o,
  output logic                             ram_re_o,
  output logic [AW-1:0]                    ram_raddr_o,
  input  logic [ptbp_pkg::ENTRY_W-1:0]     ram_rdata_i,
  output logic                             result_valid_o,
  output logic                             predict_taken_o,
  output logic                             hit_o,
  output logic [ptbp_pkg::CNT_W-1:0]       counter_value_o
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LW = (CW > ptbp_pkg::ENTRIES_W) ? CW : ptbp_pkg::ENTRIES_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  ptbp_pkg::queue_entry_t          cmd_q, cmd_d;
  logic [CW-1:0]                   rd_idx_q, rd_idx_d;
  logic [AW-1:0]                   cmp_idx_q, cmp_idx_d;
  logic                            res_valid_q, res_valid_d;
  logic                            res_taken_q, res_taken_d;
  logic                            res_hit_q, res_hit_d;
  logic [ptbp_pkg::CNT_W-1:0]      res_cnt_q, res_cnt_d;

  logic [LW-1:0]                   limit_lw;
  logic [CW-1:0]                   limit;
  logic [ptbp_pkg::ADDR_W-1:0]     rd_addr;
  logic [ptbp_pkg::CNT_W-1:0]      rd_cnt;
  logic [ptbp_pkg::CNT_W-1:0]      new_cnt;
  logic [ptbp_pkg::CNT_W-1:0]      out_cnt;
  logic                            match;

  // clamp the configured count to the table size
  assign limit_lw = (LW'(entries_in_use_i) > LW'(TABLE_ENTRIES)) ?
                    LW'(TABLE_ENTRIES) : LW'(entries_in_use_i);
  assign limit    = limit_lw[CW-1:0];

  assign rd_addr = ram_rdata_i[ptbp_pkg::ENTRY_W-1:ptbp_pkg::CNT_W];
  assign rd_cnt  = ram_rdata_i[ptbp_pkg::CNT_W-1:0];
  assign match   = rd_addr == cmd_q.addr;

  always_comb begin
    new_cnt = rd_cnt;
    if (cmd_q.taken) begin
      if (rd_cnt != ptbp_pkg::CNT_MAX) new_cnt = rd_cnt + 1'b1;
    end else begin
      if (rd_cnt != ptbp_pkg::CNT_MIN) new_cnt = rd_cnt - 1'b1;
    end
  end

  assign out_cnt = (cmd_q.kind == ptbp_pkg::KIND_UPDATE) ? new_cnt : rd_cnt;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    res_valid_d = 1'b0;
    res_taken_d = 1'b0;
    res_hit_d   = 1'b0;
    res_cnt_d   = ptbp_pkg::CNT_MIN;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i.entry;
          unique case (head_i.entry.kind)
            ptbp_pkg::KIND_LOAD: begin
              ram_we_o    = head_i.entry.slot_ok;
              ram_waddr_o = AW'(head_i.entry.slot);
              ram_wdata_o = {head_i.entry.addr, ptbp_pkg::CNT_MIN};
              res_valid_d = 1'b1;
            end
            ptbp_pkg::KIND_PREDICT, ptbp_pkg::KIND_UPDATE: begin
              if (limit == '0) begin
                res_valid_d = 1'b1;
              end else begin
                // start the scan at slot zero
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                cmp_idx_d   = '0;
                rd_idx_d    = CW'(1);
                state_d     = ST_SCAN;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        priority if (match) begin
          ram_we_o    = cmd_q.kind == ptbp_pkg::KIND_UPDATE;
          ram_waddr_o = cmp_idx_q;
          ram_wdata_o = {cmd_q.addr, new_cnt};
          res_valid_d = 1'b1;
          res_hit_d   = 1'b1;
          res_cnt_d   = out_cnt;
          res_taken_d = out_cnt >= ptbp_pkg::CNT_TAKEN_MIN;
          state_d     = ST_IDLE;
        end else if (rd_idx_q < limit) begin
          // advance to the next slot
          ram_re_o    = 1'b1;
          ram_raddr_o = rd_idx_q[AW-1:0];
          cmp_idx_d   = rd_idx_q[AW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
        end else begin
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    rd_idx_q    <= rd_idx_d;
    cmp_idx_q   <= cmp_idx_d;
    res_taken_q <= res_taken_d;
    res_hit_q   <= res_hit_d;
    res_cnt_q   <= res_cnt_d;
  end

  assign result_valid_o  = res_valid_q;
  assign predict_taken_o = res_taken_q;
  assign hit_o           = res_hit_q;
  assign counter_value_o = res_cnt_q;

endmodule

// ----- rtl/per_branch_two_bit_predictor_top.sv -----
// Top level of the per-branch two-bit saturating counter predictor.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------------------------
//  command   | start / busy                  | operation_i slot_i branch_address_i taken_i
//  result    | result_valid_o (1-cycle strobe)| predict_taken_o hit_o counter_value_o
//  config    | cfg_valid_i / cfg_ready_o     | cfg_data_i (entries_in_use)
//
// A transaction is taken when start is high and busy is low; a two-entry queue
// lets commands enter while the execution unit scans. With the queue empty, a load,
// an unknown operation or a search with no entries in use passes through the queue
// entry and then the registered result; a search reads one table slot per
// cycle via the single RAM read port, up to min(entries_in_use, TABLE_ENTRIES) slots.
// Commands waiting in the queue add the time of those ahead of them.
// Reset clears the queue, sequencer and entries_in_use; table contents are kept.
// The receiver cannot stall: every result strobe is consumed.
module per_branch_two_bit_predictor_top #(
  parameter int unsigned TABLE_ENTRIES = ptbp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ptbp_pkg::OP_W-1:0]        operation_i,
  input  logic [ptbp_pkg::SLOT_W-1:0]      slot_i,
  input  logic [ptbp_pkg::ADDR_W-1:0]      branch_address_i,
  input  logic                             taken_i,
  output logic                             result_valid_o,
  output logic                             predict_taken_o,
  output logic                             hit_o,
  output logic [ptbp_pkg::CNT_W-1:0]       counter_value_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptbp_pkg::ENTRIES_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ptbp_pkg::queue_xfer_t             push;
  ptbp_pkg::queue_xfer_t             head;
  logic                              q_full;
  logic                              pop;
  logic [ptbp_pkg::ENTRIES_W-1:0]    entries_q;
  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic [ptbp_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_data_i;
    end
  end

  ptbp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .branch_address_i (branch_address_i),
    .taken_i          (taken_i),
    .q_full_i         (q_full),
    .push_o           (push)
  );

  ptbp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ptbp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .entries_in_use_i (entries_q),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .result_valid_o   (result_valid_o),
    .predict_taken_o  (predict_taken_o),
    .hit_o            (hit_o),
    .counter_value_o  (counter_value_o)
  );

  // each slot holds {branch address, counter}
  ptbp_ram #(
    .WIDTH (ptbp_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- sim/tb_per_branch_two_bit_predictor_top.sv -----
// Self-checking testbench of the per-branch two-bit predictor: directed and random commands.
module tb_per_branch_two_bit_predictor_top;
  import ptbp_pkg::*;

  localparam int unsigned     CLK_HALF       = 6;
  localparam longint unsigned TIMEOUT_CYCLES = 1_500_000;
  localparam int unsigned     IDLE_GUARD     = 4;
  localparam int unsigned     DRAIN_CYCLES   = 300;
  localparam int unsigned     POOL_SIZE      = 16;

  typedef struct packed {
    logic             predict_taken;
    logic             hit;
    logic [CNT_W-1:0] counter;
  } outcome_t;

  // Mirror of the branch table; turns each accepted command into its expected outcome
  class branch_outcome_board;
    logic [ADDR_W-1:0] slot_addr [TABLE_ENTRIES_DEF];
    logic [CNT_W-1:0]  slot_cnt  [TABLE_ENTRIES_DEF];
    int unsigned       entries;
    outcome_t          outcome_q [$];
    int unsigned       errors;
    int unsigned       n_cmd;
    int unsigned       n_hit;
    int unsigned       n_sat;
    int unsigned       n_kind [4];

    function int unsigned search_span();
      return (entries > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : entries;
    endfunction

    function void note_command(op_kind_e kind, logic [SLOT_W-1:0] slot,
                               logic [ADDR_W-1:0] addr, logic taken);
      outcome_t         exp_o;
      int               match;
      logic [CNT_W-1:0] cnt;
      exp_o = '0;
      match = -1;
      cnt   = CNT_MIN;
      n_cmd++;
      n_kind[kind]++;
      case (kind)
        KIND_LOAD: begin
          slot_addr[slot] = addr;
          slot_cnt[slot]  = CNT_MIN;
        end
        KIND_PREDICT, KIND_UPDATE: begin
          // first match wins
          for (int k = 0; k < int'(search_span()); k++)
            if (match < 0 && slot_addr[k] == addr) match = k;
          if (match >= 0) begin
            cnt = slot_cnt[match];
            if (kind == KIND_UPDATE) begin
              if (taken && cnt != CNT_MAX) cnt++;
              else if (!taken && cnt != CNT_MIN) cnt--;
              else n_sat++;
              slot_cnt[match] = cnt;
            end
            n_hit++;
            exp_o.hit           = 1'b1;
            exp_o.counter       = cnt;
            exp_o.predict_taken = (cnt >= CNT_TAKEN_MIN);
          end
        end
        default: ;
      endcase
      outcome_q.push_back(exp_o);
    endfunction

    function void check_outcome(logic pt, logic hit, logic [CNT_W-1:0] cnt);
      outcome_t exp_o;
      if (outcome_q.size() == 0) begin
        $error("result with no command waiting: predict_taken %0d hit %0d counter_value %0d",
               pt, hit, cnt);
        errors++;
        return;
      end
      exp_o = outcome_q.pop_front();
      if (pt !== exp_o.predict_taken) begin
        $error("predict_taken: expected %0d, got %0d", exp_o.predict_taken, pt);
        errors++;
      end
      if (hit !== exp_o.hit) begin
        $error("hit: expected %0d, got %0d", exp_o.hit, hit);
        errors++;
      end
      if (cnt !== exp_o.counter) begin
        $error("counter_value: expected %0d, got %0d", exp_o.counter, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      operation_i;
  logic [SLOT_W-1:0]    slot_i;
  logic [ADDR_W-1:0]    branch_address_i;
  logic                 taken_i;
  logic                 result_valid_o;
  logic                 predict_taken_o;
  logic                 hit_o;
  logic [CNT_W-1:0]     counter_value_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [ENTRIES_W-1:0] cfg_data_i;

  branch_outcome_board  board = new();
  logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];
  logic [ADDR_W-1:0]    last_addr;
  logic [ENTRIES_W-1:0] span_plan [9] = '{9'd3, 9'd1, 9'd256, 9'd17, 9'd511,
                                         9'd0, 9'd64, 9'd300, 9'd0};
  bit                   no_idle;
  int unsigned          taken_bias;
  int unsigned          n_settings;

  per_branch_two_bit_predictor_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .slot_i           (slot_i),
    .branch_address_i (branch_address_i),
    .taken_i          (taken_i),
    .result_valid_o   (result_valid_o),
    .predict_taken_o  (predict_taken_o),
    .hit_o            (hit_o),
    .counter_value_o  (counter_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("tb: failure");
    $finish;
  end

  // Check results before noting a transaction accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        board.check_outcome(predict_taken_o, hit_o, counter_value_o);
      if (start && !busy)
        board.note_command(op_kind_e'(operation_i), slot_i, branch_address_i, taken_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keep start high across back-to-back transactions; drop it only for a gap
  task automatic issue(op_kind_e kind, logic [SLOT_W-1:0] slot,
                       logic [ADDR_W-1:0] addr, logic taken);
    int unsigned gap;
    start            <= 1'b1;
    operation_i      <= kind;
    slot_i           <= slot;
    branch_address_i <= addr;
    taken_i          <= taken;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait one edge first so a transaction accepted at the current edge is already noted
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.outcome_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic set_entries(logic [ENTRIES_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    board.entries = value;
    n_settings++;
  endtask

  // Mostly searches for addresses held in searched slots, so counters walk to both limits
  task automatic random_command();
    int unsigned       r;
    int unsigned       span;
    logic [ADDR_W-1:0] addr;
    op_kind_e          kind;
    r    = $urandom_range(0, 99);
    span = board.search_span();
    if (r < 10) kind = KIND_LOAD;
    else if (r < 13) kind = KIND_NOP;
    else if (r < 55) kind = KIND_PREDICT;
    else kind = KIND_UPDATE;
    r = $urandom_range(0, 99);
    if (r < 30 && kind != KIND_LOAD) addr = last_addr;
    else if (r < 75 && span != 0) addr = board.slot_addr[$urandom_range(0, span - 1)];
    else if (r < 88) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    else addr = $urandom;
    last_addr = addr;
    issue(kind, SLOT_W'($urandom), addr, $urandom_range(0, 99) < taken_bias);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    operation_i      <= KIND_LOAD;
    slot_i           <= '0;
    branch_address_i <= '0;
    taken_i          <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_data_i       <= '0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h1234_5678;
    for (int k = 3; k < POOL_SIZE; k++) addr_pool[k] = $urandom;
    last_addr  = '0;
    no_idle    = 1'b0;
    taken_bias = 50;
    n_settings = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no entries in use: every search misses
    issue(KIND_PREDICT, 8'h00, 32'h0000_0000, 1'b0);
    issue(KIND_NOP, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    issue(KIND_LOAD, 8'd0, 32'h0000_0000, 1'b1);
    issue(KIND_LOAD, 8'd1, 32'hFFFF_FFFF, 1'b0);
    issue(KIND_LOAD, 8'd2, 32'h1234_5678, 1'b0);
    issue(KIND_LOAD, 8'd3, 32'hA5A5_A5A5, 1'b1);
    issue(KIND_LOAD, 8'd4, 32'h1234_5678, 1'b0);
    issue(KIND_LOAD, 8'd5, 32'h5A5A_5A5A, 1'b0);
    issue(KIND_LOAD, 8'd6, 32'h8000_0000, 1'b1);
    issue(KIND_LOAD, 8'd7, 32'h0000_0001, 1'b0);
    issue(KIND_LOAD, 8'd255, 32'hCAFE_F00D, 1'b1);
    set_entries(9'd8);
    // saturate high, then low, on the first of two slots sharing an address
    for (int k = 0; k < 4; k++) issue(KIND_UPDATE, 8'h00, 32'h1234_5678, 1'b1);
    issue(KIND_PREDICT, 8'hFF, 32'h1234_5678, 1'b0);
    for (int k = 0; k < 4; k++) issue(KIND_UPDATE, 8'hFF, 32'h1234_5678, 1'b0);
    issue(KIND_PREDICT, 8'h00, 32'hFFFF_FFFF, 1'b1);
    // address held only outside the searched range
    issue(KIND_PREDICT, 8'h00, 32'hCAFE_F00D, 1'b0);
    issue(KIND_UPDATE, 8'h00, 32'hCAFE_F00D, 1'b1);
    // reload the first match so the duplicate further down takes over
    issue(KIND_LOAD, 8'd2, 32'h0BAD_0BAD, 1'b0);
    issue(KIND_PREDICT, 8'h00, 32'h1234_5678, 1'b0);

    // load every slot so any search span is legal
    for (int s = 0; s < TABLE_ENTRIES_DEF; s++) begin
      if (s % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      issue(KIND_LOAD, SLOT_W'(s),
            $urandom_range(0, 1) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom,
            1'($urandom));
    end

    span_plan[8] = ENTRIES_W'($urandom_range(1, TABLE_ENTRIES_DEF));
    foreach (span_plan[p]) begin
      set_entries(span_plan[p]);
      taken_bias = $urandom_range(20, 80);
      // long searches are slow: fewer commands on the widest spans
      for (int i = 0; i < ((span_plan[p] >= TABLE_ENTRIES_DEF) ? 50 : 100); i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_command();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d commands (%0d load, %0d predict, %0d update, %0d unknown op), %0d hits",
             board.n_cmd, board.n_kind[KIND_LOAD], board.n_kind[KIND_PREDICT],
             board.n_kind[KIND_UPDATE], board.n_kind[KIND_NOP], board.n_hit);
    $display("summary: %0d search spans, %0d updates held at a counter limit, %0d mismatches",
             n_settings, board.n_sat, board.errors);
    if (board.errors == 0 && board.outcome_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
